// ===== hw/rtl/bisection_fifth_root_finder_macros.svh =====
// Assertion helpers shared by the root finder modules.
`ifndef BISECTION_FIFTH_ROOT_FINDER_MACROS_SVH
`define BISECTION_FIFTH_ROOT_FINDER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication
`define BFR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define BFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BFR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/bfr_pkg.sv =====
package bfr_pkg;

    // Field widths
    localparam int VAL_W  = 32;
    localparam int TOL_W  = 31;
    localparam int STEP_W = 7;
    localparam int MAG_W  = 64;
    localparam int IN_W   = 96;
    localparam int OUT_W  = 112;

    // Default offset in whole units (scaled by the fraction bits)
    localparam int OFFSET_UNITS = 17;

    // x^5 takes four multiply-and-shift passes
    localparam int POW_MULS = 4;
    localparam int ITER_W   = 2;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(POW_MULS - 1);

    // Saturation level of the power magnitude
    localparam logic [MAG_W-1:0] MAG_MAX = {1'b0, {(MAG_W-1){1'b1}}};

    // Controller states, one-hot
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CHECK  = 8'b0000_0010,
        ST_LOAD   = 8'b0000_0100,
        ST_MLO    = 8'b0000_1000,
        ST_MHI    = 8'b0001_0000,
        ST_ACC    = 8'b0010_0000,
        ST_SIGN   = 8'b0100_0000,
        ST_DECIDE = 8'b1000_0000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;     // take a new item into the bound registers
        logic load_x;      // start a power evaluation
        logic x_from_low;  // evaluate at the lower bound, else at the midpoint
        logic mul_lo;      // low half partial product
        logic mul_hi;      // high half partial product
        logic acc;         // combine partials, shift, saturate
        logic sign_cap;    // register sign of g at the evaluated point
        logic sa_cap;      // keep that sign as the sign at the lower bound
        logic out_step;    // bisection step: emit and update bounds
        logic out_narrow;  // emit the single step-0 result
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic narrow;      // starting width below tolerance
        logic out_free;    // output register can take an item this cycle
        logic step_last;   // the pending step ends the run
    } status_t;

endpackage

// ===== hw/rtl/bisection_fifth_root_finder.sv =====
// A narrow starting interval gives its one result after a single x^5 evaluation at the midpoint;
// otherwise the lower bound is evaluated first, then each step evaluates the midpoint and emits a result.
// Each x^5 evaluation is four 64x32 products on one shared 32x32 multiplier.
// A run has at most MAX_STEPS steps, and no new item is taken until the run ends.
// Reset (aresetn low, synchronous) clears the controller and output valid and sets offset to 17.0.
module bisection_fifth_root_finder import bfr_pkg::*; #(
    parameter int MAX_STEPS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    // s_tdata: lower_bound[31:0], upper_bound[63:32], tolerance[94:64], zero[95]
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    // m_tdata: step[6:0], low_end[38:7], high_end[70:39], midpoint[102:71],
    //          positive[103], exact_zero[104], zero[111:105]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast,
    // offset register write
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [VAL_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t st;

    // Offset writes are always taken
    assign cfg_ready = 1'b1;

    bfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    bfr_dp #(
        .MAX_STEPS (MAX_STEPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

// ===== hw/rtl/bfr_ctrl.sv =====
`include "bisection_fifth_root_finder_macros.svh"

module bfr_ctrl import bfr_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t            state_reg, state_next;
    logic              narrow_reg, narrow_next;
    logic              eval_low_reg, eval_low_next;
    logic [ITER_W-1:0] iter_reg, iter_next;

    // Items are taken only between runs
    assign s_tready = (state_reg == ST_IDLE);

    // Sequencing
    always_comb begin
        state_next    = state_reg;
        narrow_next   = narrow_reg;
        eval_low_next = eval_low_reg;
        iter_next     = iter_reg;
        cmd           = '0;
        cmd.x_from_low = eval_low_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                narrow_next   = st.narrow;
                eval_low_next = !st.narrow;
                state_next    = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load_x = 1'b1;
                iter_next  = '0;
                state_next = ST_MLO;
            end
            ST_MLO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MHI;
            end
            ST_MHI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                if (iter_reg == ITER_LAST) begin
                    state_next = ST_SIGN;
                end else begin
                    iter_next  = iter_reg + 1'b1;
                    state_next = ST_MLO;
                end
            end
            ST_SIGN: begin
                cmd.sign_cap = 1'b1;
                state_next   = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (narrow_reg) begin
                    if (st.out_free) begin
                        cmd.out_narrow = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else if (eval_low_reg) begin
                    cmd.sa_cap    = 1'b1;
                    eval_low_next = 1'b0;
                    state_next    = ST_LOAD;
                end else if (st.out_free) begin
                    cmd.out_step = 1'b1;
                    state_next   = st.step_last ? ST_IDLE : ST_LOAD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            narrow_reg   <= 1'b0;
            eval_low_reg <= 1'b0;
            iter_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            narrow_reg   <= narrow_next;
            eval_low_reg <= eval_low_next;
            iter_reg     <= iter_next;
        end
    end

    // Checks
    `BFR_ASSERT_NEXT(a_accept_check, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_CHECK, "item accepted but no interval check followed")
    `BFR_ASSERT_NEXT(a_pow_done, aclk, aresetn, state_reg == ST_ACC && iter_reg == ITER_LAST, state_reg == ST_SIGN, "power evaluation overran its passes")
    `BFR_ASSERT_NEXT(a_run_end, aclk, aresetn, state_reg == ST_DECIDE && !narrow_reg && !eval_low_reg && st.out_free && st.step_last, state_reg == ST_IDLE, "run did not end on its last step")

endmodule

// ===== hw/rtl/bfr_dp.sv =====
`include "bisection_fifth_root_finder_macros.svh"

module bfr_dp import bfr_pkg::*; #(
    parameter int MAX_STEPS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             cfg_valid,
    input  logic [VAL_W-1:0] cfg_data,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast,
    input  cmd_t             cmd,
    output status_t          st
);

    localparam logic [VAL_W-1:0]  OFFSET_RESET = VAL_W'(64'(OFFSET_UNITS) << FRAC_BITS);
    localparam logic [STEP_W-1:0] STEP_CAP     = STEP_W'(MAX_STEPS);

    // Bounds and run state
    logic signed [VAL_W-1:0] low_reg, high_reg, offset_reg;
    logic [TOL_W-1:0]        tol_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    sa_pos_reg, sa_zero_reg;
    logic                    ev_pos_reg, ev_zero_reg;

    // Power unit
    logic             neg_reg, sat_reg;
    logic [VAL_W-1:0] m_reg;
    logic [MAG_W-1:0] p_reg, mul_reg, prod_lo_reg;

    // Output register
    logic                    m_valid_reg, out_pos_reg, out_zero_reg, out_last_reg;
    logic [STEP_W-1:0]       out_step_reg;
    logic signed [VAL_W-1:0] out_low_reg, out_high_reg, out_mid_reg;

    logic signed [VAL_W:0]   sum_w, diff_w, width_next, tol_w;
    logic signed [VAL_W-1:0] mid, x_src, low_next, high_next;
    logic [VAL_W-1:0]        x_mag, mul_a;
    logic [MAG_W-1:0]        mul_out, p_shift, pow_mag;
    logic [MAG_W+VAL_W-1:0]  acc_sum;
    logic                    acc_ovf, ev_pos, ev_zero, opposite;
    logic signed [MAG_W-1:0] pow_val, offset_ext;
    logic [STEP_W-1:0]       step_next;

    // Midpoint (floor) and width checks
    assign tol_w   = {2'b00, tol_reg};
    assign sum_w   = {low_reg[VAL_W-1], low_reg} + {high_reg[VAL_W-1], high_reg};
    assign mid     = sum_w[VAL_W:1];
    assign diff_w  = {high_reg[VAL_W-1], high_reg} - {low_reg[VAL_W-1], low_reg};

    // Operand of the power unit
    assign x_src = cmd.x_from_low ? low_reg : mid;
    assign x_mag = x_src[VAL_W-1] ? VAL_W'(-x_src) : VAL_W'(x_src);

    // Shared 32x32 multiplier, one half of p per product
    assign mul_a   = cmd.mul_hi ? p_reg[MAG_W-1:VAL_W] : p_reg[VAL_W-1:0];
    assign mul_out = MAG_W'(mul_a) * MAG_W'(m_reg);

    // Recombine halves; anything above 64 bits means overflow
    assign acc_sum = {mul_reg, {VAL_W{1'b0}}} + {{VAL_W{1'b0}}, prod_lo_reg};
    assign acc_ovf = |acc_sum[MAG_W+VAL_W-1:MAG_W];
    assign p_shift = acc_sum[MAG_W-1:0] >> FRAC_BITS;

    // Signed power against offset
    assign pow_mag    = sat_reg ? MAG_MAX : p_reg;
    assign pow_val    = neg_reg ? -$signed(pow_mag) : $signed(pow_mag);
    assign offset_ext = {{(MAG_W-VAL_W){offset_reg[VAL_W-1]}}, offset_reg};
    assign ev_pos     = pow_val > offset_ext;
    assign ev_zero    = pow_val == offset_ext;

    // Bracket update: upper end moves only on strictly opposite signs
    assign opposite   = !sa_zero_reg && (sa_pos_reg != ev_pos_reg);
    assign high_next  = opposite ? mid : high_reg;
    assign low_next   = opposite ? low_reg : mid;
    assign width_next = {high_next[VAL_W-1], high_next} - {low_next[VAL_W-1], low_next};
    assign step_next  = step_reg + 1'b1;

    assign st.narrow    = diff_w < tol_w;
    assign st.out_free  = !m_valid_reg || m_tready;
    assign st.step_last = ev_zero_reg || (width_next < tol_w) || (step_next >= STEP_CAP);

    // Configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= OFFSET_RESET;
        end else if (cfg_valid) begin
            offset_reg <= cfg_data;
        end
    end

    // Bounds, step count and bracket signs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= '0;
            high_reg <= '0;
            step_reg <= '0;
        end else begin
            if (cmd.load_in) begin
                low_reg  <= s_tdata[VAL_W-1:0];
                high_reg <= s_tdata[2*VAL_W-1:VAL_W];
                tol_reg  <= s_tdata[2*VAL_W+TOL_W-1:2*VAL_W];
                step_reg <= '0;
            end
            if (cmd.sign_cap) begin
                ev_pos_reg  <= ev_pos;
                ev_zero_reg <= ev_zero;
            end
            if (cmd.sa_cap) begin
                sa_pos_reg  <= ev_pos_reg;
                sa_zero_reg <= ev_zero_reg;
            end
            if (cmd.out_step) begin
                step_reg <= step_next;
                if (!ev_zero_reg) begin
                    low_reg  <= low_next;
                    high_reg <= high_next;
                    // lower end replaced: its sign is the midpoint's
                    if (!opposite) begin
                        sa_pos_reg  <= ev_pos_reg;
                        sa_zero_reg <= ev_zero_reg;
                    end
                end
            end
        end
    end

    // Power unit: four passes of p = (p * m) >> FRAC_BITS, sticky saturation
    always_ff @(posedge aclk) begin
        if (cmd.load_x) begin
            neg_reg <= x_src[VAL_W-1];
            m_reg   <= x_mag;
            p_reg   <= MAG_W'(x_mag);
            sat_reg <= 1'b0;
        end
        if (cmd.mul_lo) begin
            mul_reg <= mul_out;
        end
        if (cmd.mul_hi) begin
            prod_lo_reg <= mul_reg;
            mul_reg     <= mul_out;
        end
        if (cmd.acc && !sat_reg) begin
            if (acc_ovf) begin
                sat_reg <= 1'b1;
            end else begin
                p_reg <= p_shift;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_step || cmd.out_narrow) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_step || cmd.out_narrow) begin
            out_step_reg <= cmd.out_step ? step_next : '0;
            out_low_reg  <= low_reg;
            out_high_reg <= high_reg;
            out_mid_reg  <= mid;
            out_pos_reg  <= ev_pos_reg;
            out_zero_reg <= ev_zero_reg;
            out_last_reg <= cmd.out_narrow || st.step_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_W-STEP_W-3*VAL_W-2){1'b0}}, out_zero_reg, out_pos_reg,
                       out_mid_reg, out_high_reg, out_low_reg, out_step_reg};

    // Checks
    `BFR_ASSERT_NEXT(a_out_load, aclk, aresetn, cmd.out_step || cmd.out_narrow, m_valid_reg, "loaded result not presented")
    `BFR_ASSERT_IMPL(a_step_cap, aclk, aresetn, 1'b1, step_reg <= STEP_CAP, "step count beyond cap")
    `BFR_ASSERT_NEXT(a_sat_sticky, aclk, aresetn, sat_reg && !cmd.load_x, sat_reg, "saturation lost mid evaluation")

endmodule
